>>> hw/rtl/dnsq_pkg.sv
// Shared types and constants for the DNS query-name label parser.
// No dependencies; imported by every module of the block.
package dnsq_pkg;

    localparam int unsigned POS_W  = 12;
    localparam int unsigned CHAR_W = 12;

    localparam logic [POS_W-1:0]  HDR_BYTES         = 12'd12;
    localparam logic [POS_W-1:0]  POS_MAX           = 12'd4095;
    localparam logic [POS_W-1:0]  MAX_PAYLOAD_BYTES = 12'd2048;
    localparam logic [CHAR_W-1:0] MAX_CHARS_RESET   = 12'd1023;
    localparam logic [7:0]        PTR_MASK          = 8'hC0;
    localparam logic [7:0]        DOT_CHAR          = 8'h2E;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_LABEL  = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] name_char;
        logic       char_valid;
        logic       done_res;
        t_status    status;
    } t_res;

endpackage

>>> hw/rtl/dnsq_in_stage.sv
// Input register of the parser: captures one word from the slave side.
// Depends on dnsq_pkg.
module dnsq_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dnsq_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output dnsq_pkg::t_item o_item
);
    import dnsq_pkg::*;

    logic  r_vld;
    t_item r_item;

    // accept when empty or when the held word leaves this cycle
    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hw/rtl/dnsq_core.sv
// Parse state and per-word next-state logic for the query-name decoder.
// Depends on dnsq_pkg.
module dnsq_core #(
    parameter logic [dnsq_pkg::POS_W-1:0] MAX_PAYLOAD = dnsq_pkg::MAX_PAYLOAD_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dnsq_pkg::CHAR_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    input  dnsq_pkg::t_item             i_item,
    input  logic                        i_room,
    output logic                        o_take,
    output logic                        o_res_valid,
    output dnsq_pkg::t_res              o_res
);
    import dnsq_pkg::*;

    logic [CHAR_W-1:0] r_max_chars;
    logic [POS_W-1:0]  r_pos,   n_pos;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_rem,   n_rem;
    logic [CHAR_W-1:0] r_chars, n_chars;
    logic              r_seen,  n_seen;

    logic       emit;
    logic [7:0] ch;
    logic       in_range;
    logic [7:0] rem_dec;

    assign in_range = (r_pos >= HDR_BYTES) && (r_pos < MAX_PAYLOAD);
    assign rem_dec  = r_rem - 8'd1;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_chars = r_chars;
        n_seen  = r_seen;
        emit    = 1'b0;
        ch      = 8'd0;

        if (i_item.byte_valid) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 12'd1;
            end
            if (in_range) begin
                case (r_phase)
                    PH_HEADER, PH_LENGTH: begin
                        if ((r_chars >= r_max_chars) || (i_item.data_byte == 8'd0)) begin
                            n_phase = PH_STOP;
                        end else begin
                            if (r_seen) begin
                                emit    = 1'b1;
                                ch      = DOT_CHAR;
                                n_chars = r_chars + 12'd1;
                            end
                            n_seen = 1'b1;
                            if ((i_item.data_byte & PTR_MASK) == PTR_MASK) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_rem   = i_item.data_byte;
                                n_phase = PH_LABEL;
                            end
                        end
                    end
                    PH_LABEL: begin
                        emit    = 1'b1;
                        ch      = i_item.data_byte;
                        n_chars = r_chars + 12'd1;
                        n_rem   = rem_dec;
                        if (rem_dec == 8'd0) begin
                            n_phase = PH_LENGTH;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
                // stop once the character budget is spent
                if ((n_phase != PH_STOP) && (n_chars >= r_max_chars)) begin
                    n_phase = PH_STOP;
                end
            end
        end

        o_res.name_char  = ch;
        o_res.char_valid = emit;
        o_res.done_res   = i_item.last_byte;
        o_res.status     = ST_OK;
        if (i_item.last_byte) begin
            if (n_pos <= HDR_BYTES) begin
                o_res.status = ST_MALFORMED;
            end else if (n_chars == '0) begin
                o_res.status = ST_EMPTY;
            end
        end
    end

    assign o_res_valid = i_valid && (emit || i_item.last_byte);
    // a word with no result never waits for the output side
    assign o_take      = i_valid && (i_room || !(emit || i_item.last_byte));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RESET;
        end else if (i_cfg_we) begin
            r_max_chars <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_rem   <= '0;
            r_chars <= '0;
            r_seen  <= 1'b0;
        end else if (o_take) begin
            if (i_item.last_byte) begin
                r_pos   <= '0;
                r_phase <= PH_HEADER;
                r_rem   <= '0;
                r_chars <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_rem   <= n_rem;
                r_chars <= n_chars;
                r_seen  <= n_seen;
            end
        end
    end

endmodule

>>> hw/rtl/dnsq_out_stage.sv
// Result register on the master side; holds a word while the sink stalls.
// Depends on dnsq_pkg.
module dnsq_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  dnsq_pkg::t_res i_res,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output dnsq_pkg::t_res o_res
);
    import dnsq_pkg::*;

    logic r_vld;
    t_res r_res;

    assign o_room  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_room) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hw/rtl/dns_qname_label_parser.sv
// DNS query-name label parser, top level.
// Slave stream: one payload byte per word; tuser = byte present flag, tlast = last
// word of the packet (an empty packet is a single word with tuser low).
// The first 12 bytes are skipped, then the first query name is decoded: each label's
// characters go out one per word, with a dot before every label after the first.
// Decoding stops at a zero length, a compression pointer or when max_chars
// characters are out; further bytes are counted until tlast.
// Master stream: tdata = character, tuser[0] = character present, tuser[2:1] = status
// (ok, malformed, empty name) on the tlast word; tlast marks the packet's final
// result, and a character of the last byte rides in that same word.
// Words that produce nothing are absorbed without output.
// Accepted words pass the input register, then the result register. Throughput: one word
// per cycle when not stalled; the only loop is the parse state update. Stalls: while
// m_axis_tready is low the result is held and the input register fills; s_axis_tready then
// drops. Reset (synchronous, i_rst_n low) clears both stages, the parse state and sets
// max_chars to 1023. i_cfg_we writes max_chars; the user must write it only when idle (not enforced).
// Depends on dnsq_pkg, dnsq_in_stage, dnsq_core and dnsq_out_stage.
module dns_qname_label_parser #(
    parameter logic [dnsq_pkg::POS_W-1:0] MAX_PAYLOAD = dnsq_pkg::MAX_PAYLOAD_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dnsq_pkg::CHAR_W-1:0] i_cfg_wdata,   // max_chars
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  logic                        s_axis_tuser,  // [0] byte_valid
    input  logic                        s_axis_tlast,  // last_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // [7:0] name_char
    output logic [2:0]                  m_axis_tuser,  // [0] char_valid, [2:1] status
    output logic                        m_axis_tlast   // done_res
);
    import dnsq_pkg::*;

    t_item in_item, stg_item;
    t_res  core_res, out_res;
    logic  stg_valid, take, room, res_valid;

    assign in_item.data_byte  = s_axis_tdata;
    assign in_item.byte_valid = s_axis_tuser;
    assign in_item.last_byte  = s_axis_tlast;

    dnsq_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    dnsq_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (stg_valid),
        .i_item      (stg_item),
        .i_room      (room),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    dnsq_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (core_res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.name_char;
    assign m_axis_tuser = {out_res.status, out_res.char_valid};
    assign m_axis_tlast = out_res.done_res;

endmodule

>>> hw/rtl/dnsq_checker.sv
// Port-level checks for the DNS query-name label parser, bound to the top level.
// Depends on dnsq_pkg and dns_qname_label_parser.
module dnsq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import dnsq_pkg::*;

    // a stalled result word must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("result word changed under stall");

    // every word carries a character or ends a packet
    a_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
        else $error("empty result word");

    // status only on the packet's final word
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_OK))
        else $error("status outside final word");

    // no character means a zero data byte
    a_nochar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("data without character flag");

endmodule

bind dns_qname_label_parser dnsq_checker u_dnsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
